@@ rtl/gspi_pkg.sv @@
// shared types, codes and single-qubit Clifford helpers of the graph state block
package gspi_pkg;

  // item operation codes
  localparam logic OP_APPLY = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // pauli codes, bit0 x and bit1 z
  localparam logic [1:0] PAULI_I = 2'b00;
  localparam logic [1:0] PAULI_X = 2'b01;
  localparam logic [1:0] PAULI_Z = 2'b10;
  localparam logic [1:0] PAULI_Y = 2'b11;

  // per-qubit local word: frame in bits 1:0, local clifford in bits 5:2
  localparam logic [5:0] LOC_RESET = 6'b011000;

  // register map, decoded on address bit 2
  localparam logic       REG_ACTIVE_QUBITS = 1'b0;
  localparam logic [6:0] ACTIVE_RESET      = 7'd64;

  // operations of the shared row and local unit
  typedef enum logic [2:0] {
    EX_RD,
    EX_CZ,
    EX_CX,
    EX_SZ,
    EX_LC,
    EX_FX,
    EX_FIND
  } ex_op_e;

  typedef struct packed {
    logic       start;
    ex_op_e     op;
    logic [1:0] fmask;
  } ex_req_t;

  typedef struct packed {
    logic done;
    logic found;
  } ex_status_t;

  // frame flips that follow a controlled-y sequence
  typedef struct packed {
    logic fb3;
    logic fa2;
  } cy_post_t;

  function automatic logic clifford_flag(input logic [3:0] g);
    return ((g[0] ^ g[3]) == 1'b0) && ((g[0] ^ g[1] ^ g[2]) == 1'b0);
  endfunction

  function automatic logic [5:0] loc_sqrt_z(input logic [5:0] loc);
    logic [3:0] g;
    logic       z;
    g = loc[5:2];
    z = loc[1] ^ loc[0] ^ clifford_flag(g);
    return {g ^ {2'b00, g[3:2]}, z, loc[0]};
  endfunction

  function automatic logic [5:0] loc_sqrt_x_dag(input logic [5:0] loc);
    logic [3:0] g;
    logic       x;
    g = loc[5:2];
    x = loc[0] ^ loc[1] ^ clifford_flag(g);
    return {g ^ {g[1:0], 2'b00}, loc[1], x};
  endfunction

  // maps a pauli through the local gate: {sign, z, x}
  function automatic logic [2:0] to_inner(input logic [5:0] loc, input logic x,
                                          input logic z);
    logic [3:0] g;
    logic       ox;
    logic       oz;
    logic       s;
    g  = loc[5:2];
    ox = (x & g[3]) ^ (z & g[2]);
    oz = (x & g[1]) ^ (z & g[0]);
    s  = (loc[0] & oz) ^ (loc[1] & ox);
    s  = s ^ ((ox == oz) && clifford_flag(g));
    return {s, oz, ox};
  endfunction

endpackage

@@ rtl/gspi_exec.sv @@
// shared row and local unit: adjacency and local memories with sweep sequencer
module gspi_exec #(
  parameter int unsigned MAX_QUBITS = 64
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  gspi_pkg::ex_req_t                       req_i,
  input  logic [$clog2(MAX_QUBITS)-1:0]           u_i,
  input  logic [$clog2(MAX_QUBITS)-1:0]           v_i,
  input  logic [$clog2(MAX_QUBITS+1)-1:0]         count_i,
  output gspi_pkg::ex_status_t                    status_o,
  output logic [MAX_QUBITS-1:0]                   row_o,
  output logic [5:0]                              loc_o,
  output logic [$clog2(MAX_QUBITS)-1:0]           idx_o
);
  import gspi_pkg::*;

  localparam int unsigned QW = $clog2(MAX_QUBITS);
  localparam int unsigned CW = $clog2(MAX_QUBITS + 1);
  localparam logic [MAX_QUBITS-1:0] RowOne = MAX_QUBITS'(1);

  typedef enum logic [12:0] {
    X_IDLE   = 13'b1 << 0,
    X_RD     = 13'b1 << 1,
    X_CZ_W1  = 13'b1 << 2,
    X_CZ_R2  = 13'b1 << 3,
    X_CZ_W2  = 13'b1 << 4,
    X_CX_C   = 13'b1 << 5,
    X_CX_N   = 13'b1 << 6,
    X_LC_C   = 13'b1 << 7,
    X_SW_R   = 13'b1 << 8,
    X_SW_W   = 13'b1 << 9,
    X_LOC_W  = 13'b1 << 10,
    X_FD_C   = 13'b1 << 11,
    X_FD_S   = 13'b1 << 12
  } ex_state_e;

  ex_state_e state_q, state_d;
  ex_op_e    op_q, op_d;
  logic [QW-1:0] u_q, u_d, v_q, v_d, idx_q, idx_d;
  logic [1:0]    fmask_q, fmask_d;
  logic [CW-1:0] k_q, k_d;
  logic [QW-1:0] kx;
  logic [MAX_QUBITS-1:0] scr_q, scr_d, row_q, row_d;
  logic [5:0]    loc_q, loc_d;
  logic          found_q, found_d, done_q, done_d;
  logic [MAX_QUBITS-1:0] act_mask;

  // memories and their valid bits
  logic [MAX_QUBITS-1:0] adj_mem [MAX_QUBITS];
  logic [5:0]            loc_mem [MAX_QUBITS];
  logic [MAX_QUBITS-1:0] adj_vld_q, loc_vld_q;
  logic [MAX_QUBITS-1:0] adj_rd_q;
  logic [5:0]            loc_rd_q;
  logic                  adj_rvld_q, loc_rvld_q;
  logic [QW-1:0]         adj_raddr, adj_waddr, loc_raddr, loc_waddr;
  logic                  adj_we, loc_we;
  logic [MAX_QUBITS-1:0] adj_wdata, adj_row;
  logic [5:0]            loc_wdata, loc_row;

  assign kx      = k_q[QW-1:0];
  assign adj_row = adj_rvld_q ? adj_rd_q : '0;
  assign loc_row = loc_rvld_q ? loc_rd_q : LOC_RESET;

  // columns below the active count
  always_comb begin
    for (int i = 0; i < MAX_QUBITS; i++) begin
      act_mask[i] = (CW'(i) < count_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adj_we) begin
      adj_mem[adj_waddr] <= adj_wdata;
    end
    if (loc_we) begin
      loc_mem[loc_waddr] <= loc_wdata;
    end
    adj_rd_q <= adj_mem[adj_raddr];
    loc_rd_q <= loc_mem[loc_raddr];
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    u_d       = u_q;
    v_d       = v_q;
    fmask_d   = fmask_q;
    k_d       = k_q;
    scr_d     = scr_q;
    row_d     = row_q;
    loc_d     = loc_q;
    idx_d     = idx_q;
    found_d   = found_q;
    done_d    = 1'b0;
    adj_raddr = u_q;
    loc_raddr = u_q;
    adj_we    = 1'b0;
    adj_waddr = u_q;
    adj_wdata = adj_row;
    loc_we    = 1'b0;
    loc_waddr = u_q;
    loc_wdata = loc_row;
    unique case (state_q)
      X_IDLE: begin
        if (req_i.start) begin
          op_d      = req_i.op;
          u_d       = u_i;
          v_d       = v_i;
          fmask_d   = req_i.fmask;
          adj_raddr = (req_i.op == EX_CX) ? v_i : u_i;
          loc_raddr = u_i;
          case (req_i.op)
            EX_RD:        state_d = X_RD;
            EX_CZ:        state_d = X_CZ_W1;
            EX_CX:        state_d = X_CX_C;
            EX_LC:        state_d = X_LC_C;
            EX_FIND:      state_d = X_FD_C;
            EX_SZ, EX_FX: state_d = X_LOC_W;
            default:      state_d = X_IDLE;
          endcase
        end
      end
      X_RD: begin
        row_d   = adj_row;
        loc_d   = loc_row;
        done_d  = 1'b1;
        state_d = X_IDLE;
      end
      X_CZ_W1: begin
        adj_we    = 1'b1;
        adj_wdata = adj_row ^ (RowOne << v_q);
        state_d   = X_CZ_R2;
      end
      X_CZ_R2: begin
        adj_raddr = v_q;
        state_d   = X_CZ_W2;
      end
      X_CZ_W2: begin
        adj_we    = 1'b1;
        adj_waddr = v_q;
        adj_wdata = adj_row ^ (RowOne << u_q);
        done_d    = 1'b1;
        state_d   = X_IDLE;
      end
      X_CX_C: begin
        scr_d   = adj_row & act_mask;
        state_d = X_CX_N;
      end
      X_CX_N: begin
        // new control row
        scr_d   = scr_q ^ adj_row;
        k_d     = '0;
        state_d = X_SW_R;
      end
      X_LC_C: begin
        scr_d   = adj_row & act_mask;
        k_d     = '0;
        state_d = X_SW_R;
      end
      X_SW_R: begin
        if (k_q == count_i) begin
          state_d = X_LOC_W;
        end else if ((op_q == EX_CX) ? (kx == u_q) : !scr_q[kx]) begin
          k_d = k_q + CW'(1);
        end else begin
          adj_raddr = kx;
          loc_raddr = kx;
          state_d   = X_SW_W;
        end
      end
      X_SW_W: begin
        adj_we    = 1'b1;
        adj_waddr = kx;
        if (op_q == EX_CX) begin
          adj_wdata = scr_q[kx] ? (adj_row | (RowOne << u_q)) : (adj_row & ~(RowOne << u_q));
        end else begin
          adj_wdata = adj_row ^ (scr_q & ~(RowOne << kx));
          loc_we    = 1'b1;
          loc_waddr = kx;
          loc_wdata = loc_sqrt_z(loc_row);
        end
        k_d     = k_q + CW'(1);
        state_d = X_SW_R;
      end
      X_LOC_W: begin
        loc_we = 1'b1;
        case (op_q)
          EX_SZ:   loc_wdata = loc_sqrt_z(loc_row);
          EX_LC:   loc_wdata = loc_sqrt_x_dag(loc_row);
          EX_FX:   loc_wdata = {loc_row[5:2], loc_row[1:0] ^ fmask_q};
          EX_CX: begin
            loc_wdata = {loc_row[5:2], loc_row[1] ^ scr_q[u_q], loc_row[0]};
            adj_we    = 1'b1;
            adj_wdata = scr_q & ~(RowOne << u_q);
          end
          default: loc_we = 1'b0;
        endcase
        done_d  = 1'b1;
        state_d = X_IDLE;
      end
      X_FD_C: begin
        scr_d   = adj_row & act_mask;
        k_d     = '0;
        state_d = X_FD_S;
      end
      X_FD_S: begin
        if (k_q == count_i) begin
          found_d = 1'b0;
          done_d  = 1'b1;
          state_d = X_IDLE;
        end else if (scr_q[kx]) begin
          found_d = 1'b1;
          idx_d   = kx;
          done_d  = 1'b1;
          state_d = X_IDLE;
        end else begin
          k_d = k_q + CW'(1);
        end
      end
      default: state_d = X_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= X_IDLE;
      done_q     <= 1'b0;
      adj_vld_q  <= '0;
      loc_vld_q  <= '0;
      adj_rvld_q <= 1'b0;
      loc_rvld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      done_q     <= done_d;
      adj_rvld_q <= adj_vld_q[adj_raddr];
      loc_rvld_q <= loc_vld_q[loc_raddr];
      if (adj_we) begin
        adj_vld_q[adj_waddr] <= 1'b1;
      end
      if (loc_we) begin
        loc_vld_q[loc_waddr] <= 1'b1;
      end
    end
  end

  // operands and results
  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    u_q     <= u_d;
    v_q     <= v_d;
    fmask_q <= fmask_d;
    k_q     <= k_d;
    scr_q   <= scr_d;
    row_q   <= row_d;
    loc_q   <= loc_d;
    idx_q   <= idx_d;
    found_q <= found_d;
  end

  assign status_o.done  = done_q;
  assign status_o.found = found_q;
  assign row_o          = row_q;
  assign loc_o          = loc_q;
  assign idx_o          = idx_q;

endmodule

@@ rtl/graph_state_pauli_interaction.sv @@
// graph state core: pauli-pauli interaction and qubit read on a stream interface
//
// Items arrive on the s_axis channel and one result per item leaves on m_axis.
// The block takes one item at a time: s_axis_tready is high only while no item
// is at work. A read, or an item refused on its fields, goes straight to the
// final read of qubit_a and puts out its result with no row operation.
// An interaction reads both local words, maps the Paulis, kicks signs into the
// frames and then runs a sequence of row operations on one shared unit over the
// adjacency memory: CZ, CX, local complementation and neighbour search. A CX
// rewrites every other active row, a local complementation only the rows of
// the neighbours of its qubit, and a neighbour search stops at the first
// neighbour it finds, so these row sweeps set how long an interaction takes.
// The result waits in an output register; a new item is taken while it waits,
// and the next result is held back until the receiver takes the first.
// Reset empties the graph, clears every frame and sets every local gate to
// Hadamard through per-row valid bits, at once, with no clearing pass. The user
// writes active_qubits over APB only while idle; the block does not enforce it.
module graph_state_pauli_interaction #(
  parameter int unsigned MAX_QUBITS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // first_x, first_z, second_x, second_z, qubit_a[5:0], qubit_b[5:0]
  input  logic [15:0] s_axis_tdata,
  // operation
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // neighbor_row[63:0], frame_pauli[1:0], local_clifford[3:0], zero fill
  output logic [71:0] m_axis_tdata,
  // error
  output logic        m_axis_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import gspi_pkg::*;

  localparam int unsigned QW = $clog2(MAX_QUBITS);
  localparam int unsigned CW = $clog2(MAX_QUBITS + 1);

  typedef enum logic [28:0] {
    S_IDLE = 29'b1 << 0,
    S_RDA  = 29'b1 << 1,
    S_RDB  = 29'b1 << 2,
    S_MAP  = 29'b1 << 3,
    S_KB   = 29'b1 << 4,
    S_KA   = 29'b1 << 5,
    S_DISP = 29'b1 << 6,
    S_DCZ  = 29'b1 << 7,
    S_DCX  = 29'b1 << 8,
    S_YZ   = 29'b1 << 9,
    S_YX   = 29'b1 << 10,
    S_YS   = 29'b1 << 11,
    S_PFA  = 29'b1 << 12,
    S_PFB  = 29'b1 << 13,
    S_YCT  = 29'b1 << 14,
    S_YCL  = 29'b1 << 15,
    S_YYL  = 29'b1 << 16,
    S_YYT  = 29'b1 << 17,
    S_XCT  = 29'b1 << 18,
    S_XBLB = 29'b1 << 19,
    S_XBLA = 29'b1 << 20,
    S_XF   = 29'b1 << 21,
    S_XKL  = 29'b1 << 22,
    S_XKT  = 29'b1 << 23,
    S_XQA  = 29'b1 << 24,
    S_XQB  = 29'b1 << 25,
    S_XQC  = 29'b1 << 26,
    S_FIN  = 29'b1 << 27,
    S_OUT  = 29'b1 << 28
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [6:0]    aq_q;
  logic [CW-1:0] cnt;
  logic [6:0]    cnt7;
  logic          cfg_wr;

  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_ACTIVE_QUBITS);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ACTIVE_QUBITS) ? {25'b0, aq_q} : 32'b0;
  assign cnt    = (aq_q > 7'(MAX_QUBITS)) ? CW'(MAX_QUBITS) : aq_q[CW-1:0];
  assign cnt7   = 7'(cnt);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aq_q <= ACTIVE_RESET;
    end else if (cfg_wr) begin
      aq_q <= pwdata[6:0];
    end
  end

  // item fields
  logic       in_op, in_x1, in_z1, in_x2, in_z2;
  logic [5:0] in_qa, in_qb;
  logic       x1_q, z1_q, x2_q, z2_q;
  logic [5:0] qa_q, qb_q;
  logic       in_accept, in_bad, qa_oor;

  assign in_op     = s_axis_tuser;
  assign in_x1     = s_axis_tdata[0];
  assign in_z1     = s_axis_tdata[1];
  assign in_x2     = s_axis_tdata[2];
  assign in_z2     = s_axis_tdata[3];
  assign in_qa     = s_axis_tdata[9:4];
  assign in_qb     = s_axis_tdata[15:10];
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign in_bad    = !(in_x1 || in_z1) || !(in_x2 || in_z2) || (in_qa == in_qb) ||
                     ({1'b0, in_qa} >= cnt7) || ({1'b0, in_qb} >= cnt7);
  assign qa_oor    = {1'b0, qa_q} >= cnt7;

  // working registers
  logic [5:0]    loc_a_q, loc_a_d, loc_b_q, loc_b_d;
  logic [2:0]    r1_q, r1_d, r2_q, r2_d;
  logic [QW-1:0] opa_q, opa_d, opb_q, opb_d, k_q, k_d;
  cy_post_t      post_q, post_d;
  logic          bit_q, bit_d, err_q, err_d;
  logic          launched_q, launched_d;
  logic          m_valid_q, m_valid_d;
  logic [71:0]   m_data_q, m_data_d;
  logic          m_user_q, m_user_d;
  logic [2:0]    map1, map2;

  assign map1 = to_inner(loc_a_q, x1_q, z1_q);
  assign map2 = to_inner(loc_b_q, x2_q, z2_q);

  // shared unit
  ex_req_t               ex_req;
  ex_status_t            ex_st;
  logic [QW-1:0]         ex_u, ex_v, ex_idx;
  logic [MAX_QUBITS-1:0] ex_row;
  logic [5:0]            ex_loc;
  logic                  step, done;

  gspi_exec #(
    .MAX_QUBITS(MAX_QUBITS)
  ) u_exec (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (ex_req),
    .u_i      (ex_u),
    .v_i      (ex_v),
    .count_i  (cnt),
    .status_o (ex_st),
    .row_o    (ex_row),
    .loc_o    (ex_loc),
    .idx_o    (ex_idx)
  );

  // operation of each step state
  always_comb begin
    step         = 1'b1;
    ex_req.op    = EX_RD;
    ex_req.fmask = 2'b00;
    ex_u         = opa_q;
    ex_v         = opb_q;
    unique case (state_q)
      S_RDA:  ex_u = qa_q[QW-1:0];
      S_RDB:  ex_u = qb_q[QW-1:0];
      S_FIN:  ex_u = qa_q[QW-1:0];
      S_KB: begin
        ex_req.op    = EX_FX;
        ex_u         = qb_q[QW-1:0];
        ex_req.fmask = r2_q[1:0];
      end
      S_KA: begin
        ex_req.op    = EX_FX;
        ex_u         = qa_q[QW-1:0];
        ex_req.fmask = r1_q[1:0];
      end
      S_DCZ, S_YZ:           ex_req.op = EX_CZ;
      S_DCX, S_YX:           ex_req.op = EX_CX;
      S_YS:                  ex_req.op = EX_SZ;
      S_YCL, S_YYL, S_XBLA:  ex_req.op = EX_LC;
      S_YCT, S_YYT, S_XCT:   ex_req.op = EX_RD;
      S_XF:                  ex_req.op = EX_FIND;
      S_XBLB: begin
        ex_req.op = EX_LC;
        ex_u      = opb_q;
      end
      S_XKL: begin
        ex_req.op = EX_LC;
        ex_u      = k_q;
      end
      S_XKT:  ex_u = opb_q;
      S_PFA: begin
        ex_req.op    = EX_FX;
        ex_req.fmask = PAULI_Z;
      end
      S_PFB, S_XQB: begin
        ex_req.op    = EX_FX;
        ex_u         = opb_q;
        ex_req.fmask = PAULI_Y;
      end
      S_XQA: begin
        ex_req.op    = EX_FX;
        ex_req.fmask = PAULI_Y;
      end
      S_XQC: begin
        ex_req.op    = EX_FX;
        ex_u         = opb_q;
        ex_req.fmask = PAULI_X;
      end
      default: step = 1'b0;
    endcase
    ex_req.start = step && !launched_q;
  end

  assign done = ex_st.done;

  // interaction sequencer
  always_comb begin
    state_d    = state_q;
    loc_a_d    = loc_a_q;
    loc_b_d    = loc_b_q;
    r1_d       = r1_q;
    r2_d       = r2_q;
    opa_d      = opa_q;
    opb_d      = opb_q;
    k_d        = k_q;
    post_d     = post_q;
    bit_d      = bit_q;
    err_d      = err_q;
    m_data_d   = m_data_q;
    m_user_d   = m_user_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    launched_d = done ? 1'b0 : (launched_q || ex_req.start);
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          err_d = 1'b0;
          if (in_op == OP_READ) begin
            err_d   = {1'b0, in_qa} >= cnt7;
            state_d = S_FIN;
          end else if (in_bad) begin
            err_d   = 1'b1;
            state_d = S_FIN;
          end else begin
            state_d = S_RDA;
          end
        end
      end
      S_RDA: begin
        if (done) begin
          loc_a_d = ex_loc;
          state_d = S_RDB;
        end
      end
      S_RDB: begin
        if (done) begin
          loc_b_d = ex_loc;
          state_d = S_MAP;
        end
      end
      S_MAP: begin
        r1_d = map1;
        r2_d = map2;
        if (map1[1:0] == PAULI_I || map2[1:0] == PAULI_I) begin
          err_d   = 1'b1;
          state_d = S_FIN;
        end else if (map1[2]) begin
          state_d = S_KB;
        end else if (map2[2]) begin
          state_d = S_KA;
        end else begin
          state_d = S_DISP;
        end
      end
      S_KB: begin
        if (done) begin
          state_d = r2_q[2] ? S_KA : S_DISP;
        end
      end
      S_KA: begin
        if (done) begin
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        // nine inner cases, some with roles swapped
        opa_d  = qa_q[QW-1:0];
        opb_d  = qb_q[QW-1:0];
        post_d = '0;
        case ({r1_q[1:0], r2_q[1:0]})
          {PAULI_X, PAULI_X}: state_d = S_XCT;
          {PAULI_Z, PAULI_X}: state_d = S_DCX;
          {PAULI_Y, PAULI_X}: state_d = S_YCT;
          {PAULI_X, PAULI_Z}: begin
            opa_d   = qb_q[QW-1:0];
            opb_d   = qa_q[QW-1:0];
            state_d = S_DCX;
          end
          {PAULI_Z, PAULI_Z}: state_d = S_DCZ;
          {PAULI_Y, PAULI_Z}: begin
            opa_d   = qb_q[QW-1:0];
            opb_d   = qa_q[QW-1:0];
            state_d = S_YZ;
          end
          {PAULI_X, PAULI_Y}: begin
            opa_d   = qb_q[QW-1:0];
            opb_d   = qa_q[QW-1:0];
            state_d = S_YCT;
          end
          {PAULI_Z, PAULI_Y}: state_d = S_YZ;
          default:            state_d = S_YYL;
        endcase
      end
      S_DCZ, S_DCX, S_PFB: begin
        if (done) begin
          state_d = S_FIN;
        end
      end
      S_YZ: begin
        if (done) begin
          state_d = S_YX;
        end
      end
      S_YX: begin
        if (done) begin
          state_d = S_YS;
        end
      end
      S_YS: begin
        if (done) begin
          state_d = post_q.fa2 ? S_PFA : S_FIN;
        end
      end
      S_PFA: begin
        if (done) begin
          state_d = post_q.fb3 ? S_PFB : S_FIN;
        end
      end
      S_YCT: begin
        if (done) begin
          bit_d   = ex_row[opb_q];
          state_d = S_YCL;
        end
      end
      S_YCL: begin
        if (done) begin
          post_d  = '{fb3: 1'b0, fa2: 1'b1};
          state_d = bit_q ? S_YZ : S_DCX;
        end
      end
      S_YYL: begin
        if (done) begin
          state_d = S_YYT;
        end
      end
      S_YYT: begin
        if (done) begin
          post_d  = '0;
          state_d = ex_row[opb_q] ? S_DCX : S_YZ;
        end
      end
      S_XCT: begin
        if (done) begin
          state_d = ex_row[opb_q] ? S_XBLB : S_XF;
        end
      end
      S_XBLB: begin
        if (done) begin
          state_d = S_XBLA;
        end
      end
      S_XBLA: begin
        if (done) begin
          post_d  = '{fb3: 1'b1, fa2: 1'b1};
          state_d = S_YZ;
        end
      end
      S_XF: begin
        if (done) begin
          k_d     = ex_idx;
          state_d = ex_st.found ? S_XKL : S_FIN;
        end
      end
      S_XKL: begin
        if (done) begin
          state_d = S_XKT;
        end
      end
      S_XKT: begin
        if (done) begin
          state_d = ex_row[k_q] ? S_XQA : S_XQC;
        end
      end
      S_XQA: begin
        if (done) begin
          state_d = S_XQB;
        end
      end
      S_XQB: begin
        if (done) begin
          state_d = S_YYL;
        end
      end
      S_XQC: begin
        if (done) begin
          state_d = S_YCT;
        end
      end
      S_FIN: begin
        if (done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        // load the output register once the previous result has gone
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_user_d  = err_q;
          m_data_d  = qa_oor ? 72'b0 : {2'b00, ex_loc[5:2], ex_loc[1:0], 64'(ex_row)};
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      launched_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      launched_q <= launched_d;
      m_valid_q  <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      x1_q <= in_x1;
      z1_q <= in_z1;
      x2_q <= in_x2;
      z2_q <= in_z2;
      qa_q <= in_qa;
      qb_q <= in_qb;
    end
    loc_a_q  <= loc_a_d;
    loc_b_q  <= loc_b_d;
    r1_q     <= r1_d;
    r2_q     <= r2_d;
    opa_q    <= opa_d;
    opb_q    <= opb_d;
    k_q      <= k_d;
    post_q   <= post_d;
    bit_q    <= bit_d;
    err_q    <= err_d;
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

`ifndef SYNTHESIS
  a_ready_unit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !launched_q)
    else $error("input ready while the shared unit still works");
  a_done_launched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ex_st.done |-> launched_q)
    else $error("shared unit finished an operation that was never started");
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second transfer taken while an item is at work");
`endif

endmodule

@@ dv/tb_top.sv @@
// testbench for the graph state pauli interaction block, with its own predictor and scoreboard
`timescale 1ns / 100ps

module tb_top;
  import gspi_pkg::*;

  // one input item as driven on the slave side
  typedef struct packed {
    logic       op;
    logic [1:0] p1;
    logic [1:0] p2;
    logic [5:0] qa;
    logic [5:0] qb;
  } gate_item_t;

  // one result item as seen on the master side
  typedef struct packed {
    logic [63:0] row;
    logic [1:0]  frame;
    logic [3:0]  cliff;
    logic        err;
  } qubit_view_t;

  // graph state predictor plus queue of expected qubit views
  class graph_scoreboard;
    logic [63:0]  adj[64];
    logic [1:0]   frm[64];
    logic [3:0]   lg[64];
    logic [6:0]   active;
    qubit_view_t  views[$];
    int           fails;
    int           seen;
    int           applied;

    function void clear_state();
      for (int k = 0; k < 64; k++) begin
        adj[k] = '0;
        frm[k] = '0;
        lg[k]  = 4'd6;
      end
      active = ACTIVE_RESET;
      fails = 0;
      seen = 0;
      applied = 0;
    endfunction

    function int unsigned count();
      return (active > 7'd64) ? 64 : int'(active);
    endfunction

    function logic [63:0] cmask();
      int unsigned n;
      n = count();
      return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
    endfunction

    function logic is_pauli_group(logic [3:0] g);
      return ((g[0] ^ g[3]) == 1'b0) && ((g[0] ^ g[1] ^ g[2]) == 1'b0);
    endfunction

    function void do_cz(int unsigned a, int unsigned b);
      adj[a][b] = ~adj[a][b];
      adj[b][a] = ~adj[b][a];
    endfunction

    function void do_cx(int unsigned c, int unsigned t);
      int unsigned n;
      n = count();
      adj[c] = adj[c] ^ (adj[t] & cmask());
      for (int unsigned k = 0; k < n; k++) adj[k][c] = adj[c][k];
      frm[c][1] = frm[c][1] ^ adj[c][c];
      adj[c][c] = 1'b0;
    endfunction

    function void do_sz(int unsigned q);
      logic [3:0] g;
      logic [1:0] f;
      g = lg[q];
      f = frm[q];
      frm[q] = {f[1] ^ f[0] ^ is_pauli_group(g), f[0]};
      lg[q] = g ^ {2'b00, g[3:2]};
    endfunction

    function void do_sxd(int unsigned q);
      logic [3:0] g;
      logic [1:0] f;
      g = lg[q];
      f = frm[q];
      frm[q] = {f[1], f[0] ^ f[1] ^ is_pauli_group(g)};
      lg[q] = g ^ {g[1:0], 2'b00};
    endfunction

    function void do_cy(int unsigned c, int unsigned t);
      do_cz(c, t);
      do_cx(c, t);
      do_sz(c);
    endfunction

    // local complementation around q
    function void loc_comp(int unsigned q);
      logic [63:0] nb;
      int unsigned n;
      n = count();
      nb = adj[q] & cmask();
      for (int unsigned k = 0; k < n; k++) if (nb[k]) do_sz(k);
      for (int unsigned k = 0; k < n; k++)
        if (nb[k]) adj[k] = adj[k] ^ (nb & ~(64'd1 << k));
      do_sxd(q);
    endfunction

    function void do_ycx(int unsigned a, int unsigned b);
      if (adj[a][b]) begin
        loc_comp(a);
        do_cy(a, b);
        frm[a] ^= 2'b10;
      end else begin
        loc_comp(a);
        do_cx(a, b);
      end
    endfunction

    function void do_ycy(int unsigned a, int unsigned b);
      loc_comp(a);
      if (adj[a][b]) do_cx(a, b);
      else do_cy(a, b);
    endfunction

    function void do_xcx(int unsigned a, int unsigned b);
      int unsigned n;
      n = count();
      if (adj[a][b]) begin
        loc_comp(b);
        loc_comp(a);
        do_cy(a, b);
        frm[a] ^= 2'b10;
        frm[b] ^= 2'b11;
        return;
      end
      for (int unsigned k = 0; k < n; k++) begin
        if (adj[a][k]) begin
          loc_comp(k);
          if (adj[b][k]) begin
            frm[a] ^= 2'b11;
            frm[b] ^= 2'b11;
            do_ycy(a, b);
          end else begin
            frm[b] ^= 2'b01;
            do_ycx(a, b);
          end
          return;
        end
      end
    endfunction

    // pauli through the local gate: {sign, z, x}
    function logic [2:0] map_inner(int unsigned q, logic [1:0] p);
      logic [3:0] g;
      logic       ox;
      logic       oz;
      logic       s;
      g  = lg[q];
      ox = (p[0] & g[3]) ^ (p[1] & g[2]);
      oz = (p[0] & g[1]) ^ (p[1] & g[0]);
      s  = (frm[q][0] & oz) ^ (frm[q][1] & ox);
      s  = s ^ ((ox == oz) && is_pauli_group(g));
      return {s, oz, ox};
    endfunction

    // accepted input item: update the graph and queue the expected view
    function void note_item(gate_item_t it);
      int unsigned n;
      int unsigned a;
      int unsigned b;
      logic        err;
      logic [2:0]  r1;
      logic [2:0]  r2;
      int unsigned sel;
      qubit_view_t v;
      n = count();
      a = it.qa;
      b = it.qb;
      err = 1'b0;
      if (it.op == OP_READ) begin
        err = (a >= n);
      end else if (it.p1 == PAULI_I || it.p2 == PAULI_I || a == b || a >= n || b >= n) begin
        err = 1'b1;
      end else begin
        r1 = map_inner(a, it.p1);
        r2 = map_inner(b, it.p2);
        if (r1[1:0] == PAULI_I || r2[1:0] == PAULI_I) begin
          err = 1'b1;
        end else begin
          applied++;
          if (r1[2]) frm[b] ^= r2[1:0];
          if (r2[2]) frm[a] ^= r1[1:0];
          sel = (int'(r1[1:0]) - 1) + 3 * (int'(r2[1:0]) - 1);
          case (sel)
            0: do_xcx(a, b);
            1: do_cx(a, b);
            2: do_ycx(a, b);
            3: do_cx(b, a);
            4: do_cz(a, b);
            5: do_cy(b, a);
            6: do_ycx(b, a);
            7: do_cy(a, b);
            default: do_ycy(a, b);
          endcase
        end
      end
      v = '0;
      if (a < n) begin
        v.row = adj[a];
        v.frame = frm[a];
        v.cliff = lg[a];
      end
      v.err = err;
      views.insert(views.size(), v);
    endfunction

    // accepted result: compare with the oldest expectation
    function void check_view(qubit_view_t got);
      qubit_view_t want;
      seen++;
      if (views.size() == 0) begin
        $error("result with nothing expected: row %h", got.row);
        fails++;
        return;
      end
      want = views.pop_front();
      if (got.row !== want.row) begin
        $error("neighbor_row: expected %h, got %h", want.row, got.row);
        fails++;
      end
      if (got.frame !== want.frame) begin
        $error("frame_pauli: expected %0d, got %0d", want.frame, got.frame);
        fails++;
      end
      if (got.cliff !== want.cliff) begin
        $error("local_clifford: expected %0d, got %0d", want.cliff, got.cliff);
        fails++;
      end
      if (got.err !== want.err) begin
        $error("error: expected %0d, got %0d", want.err, got.err);
        fails++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_valid;
  logic        s_ready;
  logic [15:0] s_data;
  logic        s_user;
  logic        m_valid;
  logic        m_ready;
  logic [71:0] m_data;
  logic        m_user;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  graph_scoreboard sb;
  bit          quiet;
  int          stall_left;
  int          sent;

  graph_state_pauli_interaction dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tuser  (m_user),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver stalls
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_ready <= 1'b0;
    end else begin
      stall_left <= pick_gap();
      m_ready <= 1'b1;
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_valid && m_ready)
      sb.check_view('{row: m_data[63:0], frame: m_data[65:64], cliff: m_data[69:66],
                      err: m_user});
  end

  task automatic send_item(gate_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= it.op;
    s_data  <= {it.qb, it.qa, it.p2, it.p1};
    do @(posedge clk_i); while (!s_ready);
    sb.note_item(it);
    sent++;
  endtask

  // sender idle until every expected result is back
  task automatic drain();
    s_valid <= 1'b0;
    while (sb.views.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_active(logic [6:0] val);
    drain();
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= {REG_ACTIVE_QUBITS, 2'b00};
    pwdata  <= {25'd0, val};
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.active = val;
  endtask

  // random item, mostly well-formed interactions within the active count
  function automatic gate_item_t rand_item();
    gate_item_t it;
    int unsigned n;
    int r;
    n = sb.count();
    r = $urandom_range(0, 99);
    it = gate_item_t'($urandom);
    if (n >= 2 && r < 80) begin
      it.op = OP_APPLY;
      it.p1 = 2'($urandom_range(1, 3));
      it.p2 = 2'($urandom_range(1, 3));
      it.qa = 6'($urandom_range(0, n - 1));
      it.qb = 6'($urandom_range(0, n - 2));
      if (it.qb >= it.qa) it.qb = it.qb + 6'd1;
    end else if (n >= 1 && r < 90) begin
      it.op = OP_READ;
      it.qa = 6'($urandom_range(0, n - 1));
    end
    return it;
  endfunction

  initial begin
    logic [6:0] counts[9] = '{7'd6, 7'd127, 7'd4, 7'd0, 7'd1, 7'd2, 7'd12, 7'd64, 7'd3};
    sb = new();
    sb.clear_state();
    quiet = 1'b0;
    stall_left = 0;
    sent = 0;
    rst_ni = 1'b0;
    s_valid = 1'b0;
    s_data = '0;
    s_user = OP_APPLY;
    m_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reads at the extremes, refusals, all nine pauli pairings
    send_item('{OP_READ, PAULI_I, PAULI_I, 6'd0, 6'd0});
    send_item('{OP_READ, PAULI_Y, PAULI_Y, 6'd63, 6'd63});
    send_item('{OP_APPLY, PAULI_I, PAULI_X, 6'd1, 6'd2});
    send_item('{OP_APPLY, PAULI_Z, PAULI_I, 6'd1, 6'd2});
    send_item('{OP_APPLY, PAULI_X, PAULI_X, 6'd5, 6'd5});
    send_item('{OP_APPLY, PAULI_X, PAULI_X, 6'd0, 6'd1});
    for (int p = 1; p <= 3; p++)
      for (int q = 1; q <= 3; q++)
        send_item('{OP_APPLY, 2'(p), 2'(q), 6'(p + 3 * q), 6'(p)});
    send_item('{OP_APPLY, PAULI_Y, PAULI_Z, 6'd63, 6'd0});
    send_item('{OP_APPLY, PAULI_X, PAULI_X, 6'd0, 6'd63});
    send_item('{OP_READ, PAULI_I, PAULI_I, 6'd1, 6'd0});
    // pause the sender until every result is back
    drain();
    write_active(7'd5);
    send_item('{OP_APPLY, PAULI_X, PAULI_Z, 6'd1, 6'd5});
    send_item('{OP_READ, PAULI_I, PAULI_I, 6'd7, 6'd0});

    // random phases over several active counts
    for (int ph = 0; ph < 9; ph++) begin
      write_active(counts[ph]);
      quiet = (ph % 3 == 1);
      for (int i = 0; i < 90; i++) send_item(rand_item());
    end
    drain();
    repeat (50) @(posedge clk_i);
    $display("sent %0d items, %0d interactions carried out, %0d results checked",
             sent, sb.applied, sb.seen);
    $display("active counts from 0 to 127 covered, with sender and receiver stalls");
    if (sb.fails == 0 && sb.views.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // run limit
  initial begin
    #20ms;
    $display("timeout after %0d items", sent);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/gspi_pkg.sv
rtl/gspi_exec.sv
rtl/graph_state_pauli_interaction.sv
dv/tb_top.sv
